// ===== rtl/pfc_pkg.sv =====
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, constants and small helpers for the Playfair cipher engine.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int unsigned GRID_SIDE  = 5;
  localparam int unsigned GRID_CELLS = GRID_SIDE * GRID_SIDE;
  localparam int unsigned LETTERS    = 26;
  localparam int unsigned SLOT_W     = $clog2(GRID_CELLS);
  localparam int unsigned NUM_W      = $clog2(LETTERS + 1);
  localparam int unsigned RC_W       = $clog2(GRID_SIDE);

  localparam logic [7:0] CHAR_A  = 8'h41;
  localparam logic [7:0] CHAR_I  = 8'h49;
  localparam logic [7:0] CHAR_J  = 8'h4A;
  localparam logic [7:0] CHAR_Q  = 8'h51;
  localparam logic [7:0] CHAR_X  = 8'h58;
  localparam logic [7:0] CHAR_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LZ = 8'h7A;

  localparam logic [NUM_W-1:0]  LETTER_J   = NUM_W'(9);
  localparam logic [NUM_W-1:0]  LETTER_Z   = NUM_W'(LETTERS - 1);
  localparam logic [NUM_W-1:0]  NO_LETTER  = NUM_W'(LETTERS);
  localparam logic [SLOT_W-1:0] FULL_COUNT = SLOT_W'(GRID_CELLS);

  // Item kinds
  typedef enum logic [2:0] {
    KIND_CLEAR  = 3'd0,
    KIND_KEY    = 3'd1,
    KIND_FINISH = 3'd2,
    KIND_TEXT   = 3'd3,
    KIND_END    = 3'd4
  } kind_e;

  // Write request into the key store
  typedef struct packed {
    logic              en;
    logic [NUM_W-1:0]  letter;
    logic [SLOT_W-1:0] slot;
  } key_wr_t;

  // One result item
  typedef struct packed {
    logic [7:0] ch;
    logic       err;
    logic       last;
  } out_item_t;

  // Letter number 0..25 for 'A'..'Z', NO_LETTER otherwise
  function automatic logic [NUM_W-1:0] letter_num(input logic [7:0] c);
    logic [7:0] diff;
    diff = c - CHAR_A;
    if (c >= CHAR_A && c <= CHAR_Z) begin
      return diff[NUM_W-1:0];
    end
    return NO_LETTER;
  endfunction

  // Row of a grid cell
  function automatic logic [RC_W-1:0] slot_row(input logic [SLOT_W-1:0] s);
    if (s >= SLOT_W'(4 * GRID_SIDE)) return RC_W'(4);
    if (s >= SLOT_W'(3 * GRID_SIDE)) return RC_W'(3);
    if (s >= SLOT_W'(2 * GRID_SIDE)) return RC_W'(2);
    if (s >= SLOT_W'(GRID_SIDE))     return RC_W'(1);
    return RC_W'(0);
  endfunction

  // Cell index from row and column
  function automatic logic [SLOT_W-1:0] cell_of(input logic [RC_W-1:0] r,
                                                input logic [RC_W-1:0] c);
    return SLOT_W'({2'b00, r} * SLOT_W'(GRID_SIDE) + {2'b00, c});
  endfunction

  // Column of a grid cell
  function automatic logic [RC_W-1:0] slot_col(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] base;
    logic [SLOT_W-1:0] diff;
    base = cell_of(slot_row(s), RC_W'(0));
    diff = s - base;
    return diff[RC_W-1:0];
  endfunction

  // Step one place around the row or column: forward or back by mode
  function automatic logic [RC_W-1:0] wrap_step(input logic [RC_W-1:0] v,
                                                input logic mode);
    if (!mode) begin
      return (v == RC_W'(GRID_SIDE - 1)) ? RC_W'(0) : RC_W'(v + RC_W'(1));
    end
    return (v == RC_W'(0)) ? RC_W'(GRID_SIDE - 1) : RC_W'(v - RC_W'(1));
  endfunction

endpackage

// ===== rtl/pfc_key_store.sv =====
// ----------------------------------------------------------------------------
// pfc_key_store
// Grid memory (cell to letter) and slot memory (letter to cell), one write
// port shared by both and two registered read ports on each.
// ----------------------------------------------------------------------------
module pfc_key_store
  import pfc_pkg::*;
(
  input  logic              clk_i,
  input  key_wr_t           wr_i,
  input  logic [NUM_W-1:0]  slot_addr_a_i,
  input  logic [NUM_W-1:0]  slot_addr_b_i,
  input  logic [SLOT_W-1:0] grid_addr_a_i,
  input  logic [SLOT_W-1:0] grid_addr_b_i,
  output logic [SLOT_W-1:0] slot_a_o,
  output logic [SLOT_W-1:0] slot_b_o,
  output logic [NUM_W-1:0]  grid_a_o,
  output logic [NUM_W-1:0]  grid_b_o
);

  logic [NUM_W-1:0]  grid_mem [GRID_CELLS];
  logic [SLOT_W-1:0] slot_mem [LETTERS];

  // Write both directions of the mapping together
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      grid_mem[wr_i.slot]   <= wr_i.letter;
      slot_mem[wr_i.letter] <= wr_i.slot;
    end
  end

  // Registered reads
  always_ff @(posedge clk_i) begin
    slot_a_o <= slot_mem[slot_addr_a_i];
    slot_b_o <= slot_mem[slot_addr_b_i];
    grid_a_o <= grid_mem[grid_addr_a_i];
    grid_b_o <= grid_mem[grid_addr_b_i];
  end

endmodule

// ===== rtl/pfc_out_buf.sv =====
// ----------------------------------------------------------------------------
// pfc_out_buf
// Two-entry result buffer: takes a whole pair at once, hands out one item a
// cycle on the valid/stall output channel while the output is not stalled.
// ----------------------------------------------------------------------------
module pfc_out_buf
  import pfc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  out_item_t  first_i,
  input  out_item_t  second_i,
  output logic       empty_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  item_o
);

  logic [1:0] count_q, count_d;
  out_item_t  head_q, head_d;
  out_item_t  tail_q, tail_d;
  logic       pop;

  assign pop         = (count_q != 2'd0) && !out_stall_i;
  assign empty_o     = (count_q == 2'd0);
  assign out_valid_o = (count_q != 2'd0);
  assign item_o      = head_q;

  // Load a pair when empty, shift on each taken item
  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    tail_d  = tail_q;
    if (load_i && count_q == 2'd0) begin
      head_d  = first_i;
      tail_d  = second_i;
      count_d = 2'd2;
    end else if (pop) begin
      head_d  = tail_q;
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

endmodule

// ===== rtl/playfair_cipher_engine.sv =====
// Clear key, key byte, text byte without a pair and unused kinds are handled
//   on acceptance; key finish walks the alphabet, one letter a cycle.
// A completed pair goes through slot memory read, grid memory read, then
//   load into the two-entry output buffer once that buffer is empty.
// The block takes one item at a time; the input stalls until it is idle again.
// Reset clears key, open pair, mode and output buffer; memories stay unwritten.
// ----------------------------------------------------------------------------
// playfair_cipher_engine
// Playfair cipher with streaming key load and streaming text, built around a
// letter/cell mapping held in two small synchronous memories.
// ----------------------------------------------------------------------------
module playfair_cipher_engine
  import pfc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] kind_i,
  input  logic [7:0] in_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       pair_error_o,
  output logic       last_of_pair_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_SLOT,
    S_GRID,
    S_EMIT
  } state_e;

  state_e            state_q, state_d;
  logic              mode_q;
  logic [LETTERS-1:0] present_q, present_d;
  logic [SLOT_W-1:0] count_q, count_d;
  logic              ready_q, ready_d;
  logic              pend_valid_q, pend_valid_d;
  logic [7:0]        pend_char_q, pend_char_d;
  logic [NUM_W-1:0]  fill_q, fill_d;
  logic [7:0]        char_a_q, char_a_d;
  logic [7:0]        char_b_q, char_b_d;

  key_wr_t           wr;
  logic              in_acc;
  logic [7:0]        key_up;
  logic [7:0]        key_fold;
  logic [NUM_W-1:0]  key_num;
  logic [7:0]        text_char;
  logic [NUM_W-1:0]  num_a, num_b;
  logic              ok_a, ok_b, pair_err;
  logic [SLOT_W-1:0] slot_a, slot_b;
  logic [NUM_W-1:0]  grid_a, grid_b;
  logic [RC_W-1:0]   r1, c1, r2, c2;
  logic [RC_W-1:0]   r1_n, c1_n, r2_n, c2_n;
  logic [SLOT_W-1:0] cell_a, cell_b;
  logic              buf_empty, buf_load;
  out_item_t         item_first, item_second, item_out;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  // Normalize key byte: uppercase, J folds into I
  assign key_up    = (in_char_i >= CHAR_LA && in_char_i <= CHAR_LZ) ?
                     (in_char_i - 8'h20) : in_char_i;
  assign key_fold  = (key_up == CHAR_J) ? CHAR_I : key_up;
  assign key_num   = letter_num(key_fold);
  assign text_char = (in_char_i == CHAR_J) ? CHAR_I : in_char_i;

  // Letters of the current pair
  assign num_a    = letter_num(char_a_q);
  assign num_b    = letter_num(char_b_q);
  assign ok_a     = (num_a != NO_LETTER) && present_q[num_a];
  assign ok_b     = (num_b != NO_LETTER) && present_q[num_b];
  assign pair_err = !(ready_q && ok_a && ok_b);

  // Apply the row, column or rectangle rule to the looked-up cells
  always_comb begin
    r1   = slot_row(slot_a);
    c1   = slot_col(slot_a);
    r2   = slot_row(slot_b);
    c2   = slot_col(slot_b);
    r1_n = r1;
    c1_n = c1;
    r2_n = r2;
    c2_n = c2;
    if (r1 == r2) begin
      c1_n = wrap_step(c1, mode_q);
      c2_n = wrap_step(c2, mode_q);
    end else if (c1 == c2) begin
      r1_n = wrap_step(r1, mode_q);
      r2_n = wrap_step(r2, mode_q);
    end else begin
      c1_n = c2;
      c2_n = c1;
    end
    cell_a = cell_of(r1_n, c1_n);
    cell_b = cell_of(r2_n, c2_n);
  end

  pfc_key_store u_key_store (
    .clk_i         (clk_i),
    .wr_i          (wr),
    .slot_addr_a_i (ok_a ? num_a : NUM_W'(0)),
    .slot_addr_b_i (ok_b ? num_b : NUM_W'(0)),
    .grid_addr_a_i (cell_a),
    .grid_addr_b_i (cell_b),
    .slot_a_o      (slot_a),
    .slot_b_o      (slot_b),
    .grid_a_o      (grid_a),
    .grid_b_o      (grid_b)
  );

  // Build the two result items of the pair
  always_comb begin
    item_first.ch    = pair_err ? char_a_q : (CHAR_A + {3'b000, grid_a});
    item_first.err   = pair_err;
    item_first.last  = 1'b0;
    item_second.ch   = pair_err ? char_b_q : (CHAR_A + {3'b000, grid_b});
    item_second.err  = pair_err;
    item_second.last = 1'b1;
  end

  // Sequencer next state
  always_comb begin
    state_d      = state_q;
    present_d    = present_q;
    count_d      = count_q;
    ready_d      = ready_q;
    pend_valid_d = pend_valid_q;
    pend_char_d  = pend_char_q;
    fill_d       = fill_q;
    char_a_d     = char_a_q;
    char_b_d     = char_b_q;
    wr           = '0;
    buf_load     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (kind_i)
            KIND_CLEAR: begin
              present_d    = '0;
              count_d      = '0;
              ready_d      = 1'b0;
              pend_valid_d = 1'b0;
              pend_char_d  = '0;
            end
            KIND_KEY: begin
              if (key_num != NO_LETTER && count_q < FULL_COUNT &&
                  !present_q[key_num]) begin
                wr.en              = 1'b1;
                wr.letter          = key_num;
                wr.slot            = count_q;
                present_d[key_num] = 1'b1;
                count_d            = count_q + SLOT_W'(1);
              end
            end
            KIND_FINISH: begin
              fill_d  = '0;
              state_d = S_FILL;
            end
            KIND_TEXT: begin
              if (!pend_valid_q) begin
                pend_char_d  = text_char;
                pend_valid_d = 1'b1;
              end else if (pend_char_q != text_char) begin
                char_a_d     = pend_char_q;
                char_b_d     = text_char;
                pend_valid_d = 1'b0;
                state_d      = S_SLOT;
              end else begin
                char_a_d = text_char;
                char_b_d = (text_char == CHAR_X) ? CHAR_Q : CHAR_X;
                state_d  = S_SLOT;
              end
            end
            KIND_END: begin
              if (pend_valid_q) begin
                char_a_d     = pend_char_q;
                char_b_d     = (pend_char_q == CHAR_Z) ? CHAR_X : CHAR_Z;
                pend_valid_d = 1'b0;
                state_d      = S_SLOT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_FILL: begin
        // Append unused letters in alphabet order, J skipped
        if (fill_q != LETTER_J && count_q < FULL_COUNT && !present_q[fill_q]) begin
          wr.en             = 1'b1;
          wr.letter         = fill_q;
          wr.slot           = count_q;
          present_d[fill_q] = 1'b1;
          count_d           = count_q + SLOT_W'(1);
        end
        if (fill_q == LETTER_Z) begin
          ready_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          fill_d = fill_q + NUM_W'(1);
        end
      end
      S_SLOT: begin
        state_d = S_GRID;
      end
      S_GRID: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        // Hold until the output buffer drains
        if (buf_empty) begin
          buf_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      mode_q       <= 1'b0;
      present_q    <= '0;
      count_q      <= '0;
      ready_q      <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_char_q  <= '0;
      fill_q       <= '0;
    end else begin
      state_q      <= state_d;
      present_q    <= present_d;
      count_q      <= count_d;
      ready_q      <= ready_d;
      pend_valid_q <= pend_valid_d;
      pend_char_q  <= pend_char_d;
      fill_q       <= fill_d;
      if (cfg_we_i) begin
        mode_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    char_a_q <= char_a_d;
    char_b_q <= char_b_d;
  end

  pfc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (buf_load),
    .first_i     (item_first),
    .second_i    (item_second),
    .empty_o     (buf_empty),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .item_o      (item_out)
  );

  assign out_char_o     = item_out.ch;
  assign pair_error_o   = item_out.err;
  assign last_of_pair_o = item_out.last;

  // The grid never holds more cells than it has
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_COUNT)
    else $error("key count beyond grid size");

  // Fill count matches the letters marked present
  a_count_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(present_q) == 32'(count_q))
    else $error("key count and present letters disagree");

  // A finished key fills the whole grid
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> (count_q == FULL_COUNT))
    else $error("key ready with partial grid");

  // The first letter of a pair is always followed by its second
  a_pair_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_of_pair_o) |=>
      (out_valid_o && last_of_pair_o))
    else $error("second letter of pair missing");

endmodule

// ===== tb/sv/playfair_cipher_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_cipher_engine_tb
// Loads keys and streams text through the Playfair engine in both modes,
// predicts every letter of each emitted pair and checks the results in order
// under random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module playfair_cipher_engine_tb;
  import pfc_pkg::*;

  localparam logic [2:0]  KIND_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  KIND_SPARE_LAST  = 3'd7;
  localparam logic [7:0]  CASE_GAP         = CHAR_LA - CHAR_A;
  localparam int unsigned REPORT_LIMIT     = 10;
  localparam int unsigned QUIET_LIMIT      = 4000;
  localparam int unsigned SETTLE_CYCLES    = 40;
  localparam int unsigned HOLD_CYCLES      = 400;
  localparam int unsigned RESET_CYCLES     = 6;
  localparam logic        MODE_ENCRYPT     = 1'b0;
  localparam logic        MODE_DECRYPT     = 1'b1;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_data_i  = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [2:0] kind_i      = KIND_CLEAR;
  logic [7:0] in_char_i   = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_char_o;
  logic       pair_error_o;
  logic       last_of_pair_o;

  // Predicted key grid and text state
  logic [NUM_W-1:0]  cell_letter [GRID_CELLS];
  logic [SLOT_W-1:0] letter_cell [LETTERS];
  logic [LETTERS-1:0] present    = '0;
  int unsigned       filled      = 0;
  logic              key_done    = 1'b0;
  logic              open_valid  = 1'b0;
  logic [7:0]        open_char   = 8'h00;
  logic              mode_q      = MODE_ENCRYPT;

  out_item_t   expected_letters [$];
  int unsigned fault_count   = 0;
  int unsigned items_sent    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned hold_left     = 0;
  logic        hold_req      = 1'b0;

  playfair_cipher_engine dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .in_char_i      (in_char_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_char_o     (out_char_o),
    .pair_error_o   (pair_error_o),
    .last_of_pair_o (last_of_pair_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned to_letter(input logic [7:0] c);
    if (c >= CHAR_A && c <= CHAR_Z) begin
      return int'(c - CHAR_A);
    end
    return LETTERS;
  endfunction

  // Place a letter in the next free cell unless absent, known or grid full
  task automatic add_letter(input int unsigned n);
    if (n < LETTERS && filled < GRID_CELLS && !present[n]) begin
      cell_letter[filled] = NUM_W'(n);
      letter_cell[n]      = SLOT_W'(filled);
      present[n]          = 1'b1;
      filled++;
    end
  endtask

  // Transform one pair and queue its two letters
  task automatic cipher_pair(input logic [7:0] a, input logic [7:0] b);
    int unsigned na, nb, r1, c1, r2, c2, swap, step;
    logic [7:0]  oa, ob;
    logic        err;
    na  = to_letter(a);
    nb  = to_letter(b);
    oa  = a;
    ob  = b;
    err = 1'b1;
    if (key_done && na < LETTERS && nb < LETTERS && present[na] && present[nb]) begin
      r1   = int'(letter_cell[na]) / GRID_SIDE;
      c1   = int'(letter_cell[na]) % GRID_SIDE;
      r2   = int'(letter_cell[nb]) / GRID_SIDE;
      c2   = int'(letter_cell[nb]) % GRID_SIDE;
      step = mode_q ? GRID_SIDE - 1 : 1;
      if (r1 == r2) begin
        c1 = (c1 + step) % GRID_SIDE;
        c2 = (c2 + step) % GRID_SIDE;
      end else if (c1 == c2) begin
        r1 = (r1 + step) % GRID_SIDE;
        r2 = (r2 + step) % GRID_SIDE;
      end else begin
        swap = c1;
        c1   = c2;
        c2   = swap;
      end
      oa  = CHAR_A + 8'(cell_letter[r1 * GRID_SIDE + c1]);
      ob  = CHAR_A + 8'(cell_letter[r2 * GRID_SIDE + c2]);
      err = 1'b0;
    end
    expected_letters.push_back('{ch: oa, err: err, last: 1'b0});
    expected_letters.push_back('{ch: ob, err: err, last: 1'b1});
  endtask

  // Advance the predicted state by one accepted item
  task automatic apply_item(input logic [2:0] k, input logic [7:0] c);
    logic [7:0]  ch;
    int unsigned n;
    ch = c;
    case (k)
      KIND_CLEAR: begin
        present    = '0;
        filled     = 0;
        key_done   = 1'b0;
        open_valid = 1'b0;
        open_char  = 8'h00;
      end
      KIND_KEY: begin
        if (ch >= CHAR_LA && ch <= CHAR_LZ) ch = ch - CASE_GAP;
        if (ch == CHAR_J) ch = CHAR_I;
        add_letter(to_letter(ch));
      end
      KIND_FINISH: begin
        for (n = 0; n < LETTERS; n++) begin
          if (n != int'(LETTER_J)) add_letter(n);
        end
        key_done = 1'b1;
      end
      KIND_TEXT: begin
        if (ch == CHAR_J) ch = CHAR_I;
        if (!open_valid) begin
          open_char  = ch;
          open_valid = 1'b1;
        end else if (open_char != ch) begin
          open_valid = 1'b0;
          cipher_pair(open_char, ch);
        end else begin
          // doubled letter: pad it and keep it open for the next pair
          cipher_pair(ch, (ch == CHAR_X) ? CHAR_Q : CHAR_X);
        end
      end
      KIND_END: begin
        if (open_valid) begin
          open_valid = 1'b0;
          cipher_pair(open_char, (open_char == CHAR_Z) ? CHAR_X : CHAR_Z);
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- channels

  // Offer one item, hold it until accepted, then predict
  task automatic send_item(input logic [2:0] k, input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= k;
    in_char_i  <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    apply_item(k, c);
    if (k <= KIND_END) items_sent++;
  endtask

  // Drop valid, wait for every pending letter, then let the block go idle
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_letters.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic m);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    mode_q      = m;
  endtask

  // Drive the output stall: random, or held high for a requested stretch
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each accepted letter with the oldest prediction
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_letters.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT) begin
          $display("unexpected letter: char %h err %b last %b",
                   out_char_o, pair_error_o, last_of_pair_o);
        end
      end else begin
        want = expected_letters.pop_front();
        if (want.ch !== out_char_o || want.err !== pair_error_o ||
            want.last !== last_of_pair_o) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT) begin
            $display("mismatch: expected char %h err %b last %b, got char %h err %b last %b",
                     want.ch, want.err, want.last,
                     out_char_o, pair_error_o, last_of_pair_o);
          end
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("playfair_cipher_engine_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic [7:0] pick_key_char();
    case ($urandom_range(9))
      7, 8:    return CHAR_LA + 8'($urandom_range(25));
      9:       return 8'($urandom);
      default: return CHAR_A + 8'($urandom_range(25));
    endcase
  endfunction

  // Mostly capitals, with plenty of doubles and the padding letters
  function automatic logic [7:0] pick_text_char(input logic [7:0] prev);
    case ($urandom_range(9))
      0, 1, 2: return prev;
      3: begin
        case ($urandom_range(2))
          0:       return CHAR_X;
          1:       return CHAR_Z;
          default: return CHAR_J;
        endcase
      end
      4:       return 8'($urandom);
      5:       return CHAR_LA + 8'($urandom_range(25));
      default: return CHAR_A + 8'($urandom_range(25));
    endcase
  endfunction

  // One message: clear, key, finish, text, end; parts dropped or a random item added now and then
  task automatic send_message();
    int unsigned key_len, text_len, i;
    logic [7:0]  ch, prev;
    if ($urandom_range(9) != 0) send_item(KIND_CLEAR, 8'($urandom));
    key_len = ($urandom_range(7) == 0) ? $urandom_range(30) : $urandom_range(8);
    for (i = 0; i < key_len; i++) send_item(KIND_KEY, pick_key_char());
    if ($urandom_range(19) != 0) send_item(KIND_FINISH, 8'($urandom));
    text_len = $urandom_range(16);
    prev     = CHAR_A;
    for (i = 0; i < text_len; i++) begin
      ch = pick_text_char(prev);
      send_item(KIND_TEXT, ch);
      prev = ch;
    end
    if ($urandom_range(9) != 0) send_item(KIND_END, 8'($urandom));
    if ($urandom_range(9) == 0) send_item(3'($urandom), 8'($urandom));
  endtask

  task automatic test_directed_rules();
    logic [2:0] k;
    // text before the key is finished
    send_item(KIND_CLEAR, 8'h00);
    send_item(KIND_TEXT, CHAR_Q);
    send_item(KIND_TEXT, CHAR_Z);
    // key folding: lowercase, J to I, repeats and non-letters dropped
    send_item(KIND_KEY, CHAR_J + CASE_GAP);
    send_item(KIND_KEY, CHAR_LZ);
    send_item(KIND_KEY, CHAR_Z);
    send_item(KIND_KEY, 8'h00);
    send_item(KIND_KEY, 8'hFF);
    send_item(KIND_KEY, CHAR_X);
    send_item(KIND_FINISH, 8'h00);
    send_item(KIND_FINISH, 8'hFF);
    send_item(KIND_KEY, CHAR_A);
    // doubled letters, X after X, padding of an odd tail
    send_item(KIND_TEXT, CHAR_J);
    send_item(KIND_TEXT, CHAR_J);
    send_item(KIND_TEXT, CHAR_X);
    send_item(KIND_TEXT, CHAR_X);
    send_item(KIND_TEXT, CHAR_X);
    send_item(KIND_TEXT, CHAR_Z);
    send_item(KIND_TEXT, CHAR_Z);
    send_item(KIND_END, 8'h00);
    send_item(KIND_END, 8'h00);
    // letters outside the grid
    send_item(KIND_TEXT, CHAR_LA);
    send_item(KIND_TEXT, CHAR_LZ);
    for (k = KIND_SPARE_FIRST; k != KIND_SPARE_LAST; k++) send_item(k, 8'hFF);
    send_item(KIND_SPARE_LAST, 8'h00);
    send_item(KIND_TEXT, 8'hFF);
    send_item(KIND_END, 8'hFF);
    // clear drops an open pair
    send_item(KIND_TEXT, CHAR_Q);
    send_item(KIND_CLEAR, 8'h00);
    settle();
  endtask

  task automatic test_random_messages(input int unsigned send_pct,
                                      input int unsigned recv_pct,
                                      input logic m, input int unsigned count);
    int unsigned target;
    set_mode(m);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target        = items_sent + count;
    while (items_sent < target) send_message();
    settle();
  endtask

  // Hold the output off while text keeps coming so the input backs up
  task automatic test_output_backpressure();
    int unsigned i;
    set_mode(MODE_ENCRYPT);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_item(KIND_CLEAR, 8'h00);
    send_item(KIND_KEY, CHAR_Q);
    send_item(KIND_KEY, CHAR_Z);
    send_item(KIND_FINISH, 8'h00);
    hold_req = 1'b1;
    for (i = 0; i < 60; i++) send_item(KIND_TEXT, CHAR_A + 8'($urandom_range(25)));
    send_item(KIND_END, 8'h00);
    settle();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_mode(MODE_ENCRYPT);
    test_directed_rules();
    test_random_messages(9, 53, MODE_DECRYPT, 480);
    test_random_messages(53, 9, MODE_ENCRYPT, 480);
    test_random_messages(0, 0, MODE_DECRYPT, 480);
    test_output_backpressure();
    settle();
    if (fault_count == 0 && expected_letters.size() == 0) begin
      $display("playfair_cipher_engine_tb: PASS");
    end else begin
      $display("playfair_cipher_engine_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pfc_pkg.sv
rtl/pfc_key_store.sv
rtl/pfc_out_buf.sv
rtl/playfair_cipher_engine.sv
tb/sv/playfair_cipher_engine_tb.sv
